/* rtl/core/cma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int WIN_W        = 4;
  localparam int WINDOW_RESET = 3;
  localparam int SEEN_W       = 5;
  localparam int SEEN_MAX     = 31;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_READ = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/cma_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/cma_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module cma_div #(
  parameter int SUM_W   = 20,
  parameter int DIV_W   = 4,
  parameter int QUOT_W  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]        divisor,
  output logic                         done,
  output logic [QUOT_W-1:0]            quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [SUM_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    shifted;
  logic              ge;
  logic [SUM_W-1:0]  quo_signed;

  assign shifted    = {rem, quo[SUM_W-1]};
  assign ge         = shifted >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + SUM_W'(1)) : quo;
  assign quotient   = quo_signed[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(SUM_W);
      end else if (steps != '0) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/centered_moving_average_2d.sv */
`timescale 1ns / 1ps
`default_nettype none

// an accepted point passes ST_IDLE then ST_SCAN; each released result is summed from the ring in
// ST_READ, divided by the serial dividers in ST_DIV and registered onto the output in ST_OUT
// throughput: one point at a time, set by the single ring read port and the serial divider
// reset: control state clears and window_size returns to 3; ring contents stay undefined
module centered_moving_average_2d #(
  parameter int MAX_WINDOW = 15,
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // point_x, point_y
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // smooth_x, smooth_y
  output logic      [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [cma_pkg::WIN_W-1:0]        cfg_wdata
);

  import cma_pkg::*;

  localparam int TDATA_W = ((2*COORD_BITS+7)/8)*8;
  localparam int LIM     = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int WMAX    = (LIM < (2**WIN_W) - 1) ? LIM : (2**WIN_W) - 1;
  localparam int AW      = (WMAX < 1) ? 1 : $clog2(WMAX + 1);
  localparam int DEPTH   = 2**AW;
  localparam int SUM_W   = COORD_BITS + AW;

  state_t state;

  logic [WIN_W-1:0]      window_size;
  logic [SEEN_W-1:0]     seen;
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         out_ptr;
  logic [AW-1:0]         held;
  logic                  eos;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         rd_left;
  logic                  rd_vld;
  logic [AW-1:0]         cnt;
  logic                  done_flag;
  logic signed [SUM_W-1:0] acc_x;
  logic signed [SUM_W-1:0] acc_y;
  logic                  div_start;

  logic [2*COORD_BITS-1:0] ram_rdata;
  logic                  in_acc;

  logic [WIN_W-1:0]      w_raw;
  logic [WIN_W-1:0]      w_eff;
  logic [AW-1:0]         w_cnt;
  logic [AW-1:0]         half;
  logic                  long_mode;
  logic                  emit;
  logic [SEEN_W-1:0]     older;
  logic [AW-1:0]         left;
  logic [AW-1:0]         right;
  logic [AW-1:0]         held_m1;

  logic                  div_done_x;
  logic                  div_done_y;
  logic [COORD_BITS-1:0] quot_x;
  logic [COORD_BITS-1:0] quot_y;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // effective window
  assign w_raw     = window_size | WIN_W'(1);
  assign w_eff     = (int'(w_raw) > WMAX) ? WIN_W'(WMAX) : w_raw;
  assign w_cnt     = AW'(w_eff);
  assign half      = w_cnt >> 1;
  assign long_mode = seen >= SEEN_W'(w_cnt);
  assign emit      = (held != '0) && (eos || (long_mode && held > half));

  assign held_m1 = held - AW'(1);
  assign older   = (seen > SEEN_W'(held)) ? seen - SEEN_W'(held) : '0;
  assign left    = !long_mode ? '0 :
                   (older < SEEN_W'(half)) ? AW'(older) : half;
  assign right   = !long_mode ? '0 : (held_m1 < half) ? held_m1 : half;

  assign rd_x = ram_rdata[COORD_BITS-1:0];
  assign rd_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];

  cma_ram #(
    .WIDTH(2*COORD_BITS),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (in_acc),
    .waddr(wr_ptr),
    .wdata(s_axis_tdata[2*COORD_BITS-1:0]),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  cma_div #(
    .SUM_W (SUM_W),
    .DIV_W (AW),
    .QUOT_W(COORD_BITS)
  ) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_x),
    .divisor (cnt),
    .done    (div_done_x),
    .quotient(quot_x)
  );

  cma_div #(
    .SUM_W (SUM_W),
    .DIV_W (AW),
    .QUOT_W(COORD_BITS)
  ) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_y),
    .divisor (cnt),
    .done    (div_done_y),
    .quotient(quot_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_size   <= WIN_W'(WINDOW_RESET);
      seen          <= '0;
      wr_ptr        <= '0;
      out_ptr       <= '0;
      held          <= '0;
      eos           <= 1'b0;
      rd_left       <= '0;
      rd_vld        <= 1'b0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            wr_ptr <= wr_ptr + AW'(1);
            held   <= held + AW'(1);
            eos    <= s_axis_tlast;
            if (seen != SEEN_W'(SEEN_MAX)) begin
              seen <= seen + SEEN_W'(1);
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (emit) begin
            rd_addr   <= out_ptr - left;
            rd_left   <= left + right + AW'(1);
            cnt       <= left + right + AW'(1);
            rd_vld    <= 1'b0;
            acc_x     <= '0;
            acc_y     <= '0;
            done_flag <= eos && (held == AW'(1));
            state     <= ST_READ;
          end else begin
            if (eos) begin
              seen <= '0;
            end
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (rd_left != '0) begin
            rd_addr <= rd_addr + AW'(1);
            rd_left <= rd_left - AW'(1);
          end
          rd_vld <= (rd_left != '0);
          if (rd_vld) begin
            acc_x <= acc_x + SUM_W'(signed'(rd_x));
            acc_y <= acc_y + SUM_W'(signed'(rd_y));
          end
          if (rd_left == '0 && !rd_vld) begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done_x && div_done_y) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_ptr       <= out_ptr + AW'(1);
            held          <= held - AW'(1);
            state         <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= TDATA_W'({quot_y, quot_x});
      m_axis_tlast <= done_flag;
    end
  end

endmodule

`default_nettype wire
